### hdl/bdpc_pkg.sv
package bdpc_pkg;

	// Widths fixed by the register map and the result fields
	localparam int REG_WIDTH   = 16;
	localparam int INDEX_WIDTH = 2;

	// Register indexes
	localparam logic [INDEX_WIDTH-1:0] REG_ACTIVE_LEVEL     = 2'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_LONG_TICKS       = 2'd2;
	localparam logic [INDEX_WIDTH-1:0] REG_EXTRA_LONG_TICKS = 2'd3;

	// Register reset values (one tick per millisecond: 10 ms, 0.9 s, 3.0 s)
	localparam logic                 RST_ACTIVE_LEVEL     = 1'b0;
	localparam logic [REG_WIDTH-1:0] RST_DEBOUNCE_TICKS   = 16'd10;
	localparam logic [REG_WIDTH-1:0] RST_LONG_TICKS       = 16'd900;
	localparam logic [REG_WIDTH-1:0] RST_EXTRA_LONG_TICKS = 16'd3000;

	// Press classification reported on release
	typedef enum logic [1:0] {
		PRESS_NONE       = 2'd0,
		PRESS_SHORT      = 2'd1,
		PRESS_LONG       = 2'd2,
		PRESS_EXTRA_LONG = 2'd3
	} press_status_t;

endpackage

### hdl/button_debounce_press_classifier.sv
// Button debounce and press classifier. Each input transfer is one sample tick
// carrying the raw pin level; each produces exactly one result transfer with the
// press classification (none, short, long, extra long) and the debounced pressed
// state after that tick. The block takes one sample per clock cycle unless in_stall
// is high: the sample lands in an input register, the debounce and hold counters
// are updated by one pass of compare and increment logic, and the result is
// registered, from where it transfers when the output is not stalled.
// A stalled output holds its result while one further sample waits in the input
// register. Configuration (active level, debounce, long and extra long thresholds
// in ticks) is written through the plain write port; the user must write it only
// while no sample is in flight, as the block itself does not enforce this.
// COUNT_WIDTH sets the width of both saturating counters.
module button_debounce_press_classifier
	import bdpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]   cfg_data,
	// sample channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   pin_level,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             press_status,
	output logic                   debounced_pressed
);

	localparam int CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

	// configuration registers
	logic                 active_level_q;
	logic [REG_WIDTH-1:0] debounce_ticks_q;
	logic [REG_WIDTH-1:0] long_ticks_q;
	logic [REG_WIDTH-1:0] extra_long_ticks_q;

	// debounce state
	logic                   accepted_q;
	logic                   settling_q;
	logic [COUNT_WIDTH-1:0] settle_count_q;
	logic [COUNT_WIDTH-1:0] hold_count_q;

	// input stage
	logic pin_s1;
	logic valid_s1;

	// result stage
	press_status_t status_s2;
	logic          pressed_s2;
	logic          valid_s2;

	logic advance;

	// next-state logic
	logic                   pressed;
	logic                   accepted_d;
	logic                   settling_d;
	logic [COUNT_WIDTH-1:0] settle_inc;
	logic [COUNT_WIDTH-1:0] settle_count_d;
	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [COUNT_WIDTH-1:0] hold_count_d;
	press_status_t          status_d;
	logic [CMP_WIDTH-1:0]   hold_cmp;
	logic [CMP_WIDTH-1:0]   settle_cmp;

	// move the input register into the result register when the result slot frees
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q     <= RST_ACTIVE_LEVEL;
			debounce_ticks_q   <= RST_DEBOUNCE_TICKS;
			long_ticks_q       <= RST_LONG_TICKS;
			extra_long_ticks_q <= RST_EXTRA_LONG_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_LEVEL:     active_level_q     <= cfg_data[0];
				REG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_data;
				REG_LONG_TICKS:       long_ticks_q       <= cfg_data;
				REG_EXTRA_LONG_TICKS: extra_long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
		end
	end

	// advance both counters, saturating at all ones
	always_comb begin
		pressed    = (pin_s1 == active_level_q);
		settle_inc = (settling_q && !(&settle_count_q)) ? settle_count_q + 1'b1
		                                                 : settle_count_q;
		hold_inc   = (&hold_count_q) ? hold_count_q : hold_count_q + 1'b1;
		settle_cmp = CMP_WIDTH'(settle_inc);
		hold_cmp   = CMP_WIDTH'(hold_inc);

		accepted_d     = accepted_q;
		settling_d     = settling_q;
		settle_count_d = settle_inc;

		// start, drop or complete a debounce attempt
		if ((accepted_q != pressed) && !settling_q) begin
			settling_d     = 1'b1;
			settle_count_d = '0;
		end else if (settling_q && (settle_cmp < CMP_WIDTH'(debounce_ticks_q))) begin
			if (accepted_q == pressed) begin
				settling_d = 1'b0;
			end
		end else begin
			settling_d = 1'b0;
			accepted_d = pressed;
		end

		// restart the hold count on press, classify on release
		hold_count_d = hold_inc;
		status_d     = PRESS_NONE;
		if (accepted_d && !accepted_q) begin
			hold_count_d = '0;
		end else if (!accepted_d && accepted_q) begin
			if (hold_cmp > CMP_WIDTH'(extra_long_ticks_q)) begin
				status_d = PRESS_EXTRA_LONG;
			end else if (hold_cmp > CMP_WIDTH'(long_ticks_q)) begin
				status_d = PRESS_LONG;
			end else begin
				status_d = PRESS_SHORT;
			end
		end
	end

	// commit state once per processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q     <= 1'b0;
			settling_q     <= 1'b0;
			settle_count_q <= '0;
			hold_count_q   <= '0;
		end else if (advance) begin
			accepted_q     <= accepted_d;
			settling_q     <= settling_d;
			settle_count_q <= settle_count_d;
			hold_count_q   <= hold_count_d;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2  <= status_d;
			pressed_s2 <= accepted_d;
		end
	end

	assign out_valid         = valid_s2;
	assign press_status      = status_s2;
	assign debounced_pressed = pressed_s2;

endmodule

### tb/bdpc_press_checker.sv
`timescale 1ns / 100ps
module bdpc_press_checker
	import bdpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]   cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   pin_level,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [1:0]             press_status,
	input  logic                   debounced_pressed,
	output int                     fail_count,
	output int                     outstanding
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int MAX_SHOWN = 40;

	typedef struct packed {
		press_status_t status;
		logic          pressed;
	} tick_result_t;

	// Expected results in transfer order
	tick_result_t expected_q[$];
	tick_result_t oldest;

	// Shadow of the register map
	logic                 act_level;
	logic [REG_WIDTH-1:0] deb_ticks;
	logic [REG_WIDTH-1:0] long_ticks;
	logic [REG_WIDTH-1:0] xl_ticks;

	// Debounce and hold state
	logic                   acc_level;
	logic                   settling;
	logic [COUNT_WIDTH-1:0] settle_cnt;
	logic [COUNT_WIDTH-1:0] hold_cnt;

	int shown;

	// Count a mismatch, print the first MAX_SHOWN
	task automatic report_mismatch(input string msg);
		fail_count++;
		if (shown < MAX_SHOWN) begin
			$display("mismatch at %0t: %s", $time, msg);
			shown++;
		end
	endtask

	// Advance the debounce machine by one sample tick
	function automatic tick_result_t debounce_tick(input logic pin);
		logic         pressed;
		logic         was_pressed;
		tick_result_t r;
		pressed     = (pin == act_level);
		was_pressed = acc_level;
		if (settling && settle_cnt != COUNT_MAX)
			settle_cnt = settle_cnt + 1'b1;
		if (hold_cnt != COUNT_MAX)
			hold_cnt = hold_cnt + 1'b1;
		if (acc_level != pressed && !settling) begin
			settling   = 1'b1;
			settle_cnt = '0;
		end else if (settling && settle_cnt < deb_ticks) begin
			// drop the attempt once the level comes back
			if (acc_level == pressed)
				settling = 1'b0;
		end else begin
			settling  = 1'b0;
			acc_level = pressed;
		end
		r.status = PRESS_NONE;
		if (acc_level && !was_pressed) begin
			hold_cnt = '0;
		end else if (!acc_level && was_pressed) begin
			// extra long is checked first so it wins over long
			if (hold_cnt > xl_ticks)
				r.status = PRESS_EXTRA_LONG;
			else if (hold_cnt > long_ticks)
				r.status = PRESS_LONG;
			else
				r.status = PRESS_SHORT;
		end
		r.pressed = acc_level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			fail_count  = 0;
			outstanding = 0;
			shown       = 0;
			act_level   = RST_ACTIVE_LEVEL;
			deb_ticks   = RST_DEBOUNCE_TICKS;
			long_ticks  = RST_LONG_TICKS;
			xl_ticks    = RST_EXTRA_LONG_TICKS;
			acc_level   = 1'b0;
			settling    = 1'b0;
			settle_cnt  = '0;
			hold_cnt    = '0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_LEVEL:     act_level  = cfg_data[0];
					REG_DEBOUNCE_TICKS:   deb_ticks  = cfg_data;
					REG_LONG_TICKS:       long_ticks = cfg_data;
					REG_EXTRA_LONG_TICKS: xl_ticks   = cfg_data;
					default: ;
				endcase
			end
			// compare each result transfer with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					oldest = expected_q.pop_front();
					if (press_status !== oldest.status)
						report_mismatch($sformatf("press_status %0d, expected %0d",
							press_status, oldest.status));
					if (debounced_pressed !== oldest.pressed)
						report_mismatch($sformatf("debounced_pressed %0b, expected %0b",
							debounced_pressed, oldest.pressed));
				end
			end
			// predict each sample transfer
			if (in_valid && !in_stall)
				expected_q.push_back(debounce_tick(pin_level));
			outstanding = expected_q.size();
		end
	end

endmodule

### tb/tb_button_debounce_press_classifier.sv
`timescale 1ns / 100ps
module tb_button_debounce_press_classifier;
	import bdpc_pkg::*;

	localparam int LATENCY         = 2;
	localparam int CYCLE_LIMIT     = 60000;
	localparam int HOLD_OFF_AT     = 1000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_FROM      = 1300;
	localparam int QUIET_TO        = 1700;
	localparam int SPAN_CAP        = 400;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [INDEX_WIDTH-1:0] cfg_index = REG_ACTIVE_LEVEL;
	logic [REG_WIDTH-1:0]   cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   pin_level = 1'b0;
	logic                   out_stall = 1'b0;
	logic                   in_stall;
	logic                   out_valid;
	logic [1:0]             press_status;
	logic                   debounced_pressed;

	int fail_count;
	int outstanding;
	int sent_items = 0;
	int cycles     = 0;
	bit hold_off_done = 1'b0;

	// Settings currently loaded, used to shape the presses
	logic                 act_level = RST_ACTIVE_LEVEL;
	logic [REG_WIDTH-1:0] deb_set   = RST_DEBOUNCE_TICKS;
	logic [REG_WIDTH-1:0] long_set  = RST_LONG_TICKS;
	logic [REG_WIDTH-1:0] xl_set    = RST_EXTRA_LONG_TICKS;

	always #10 clk = ~clk;

	button_debounce_press_classifier uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.pin_level         (pin_level),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.press_status      (press_status),
		.debounced_pressed (debounced_pressed)
	);

	bdpc_press_checker press_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.pin_level         (pin_level),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.press_status      (press_status),
		.debounced_pressed (debounced_pressed),
		.fail_count        (fail_count),
		.outstanding       (outstanding)
	);

	// No idling on either side inside this stretch of samples
	function automatic bit quiet_now();
		return sent_items >= QUIET_FROM && sent_items < QUIET_TO;
	endfunction

	// Offer one sample and hold it until the transfer
	task automatic send_pin(input logic pin);
		while (!quiet_now() && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Write all four registers, one per cycle
	task automatic load_settings(input logic act, input logic [REG_WIDTH-1:0] deb,
		input logic [REG_WIDTH-1:0] lng, input logic [REG_WIDTH-1:0] xl);
		act_level = act;
		deb_set   = deb;
		long_set  = lng;
		xl_set    = xl;
		cfg_we    <= 1'b1;
		cfg_index <= REG_ACTIVE_LEVEL;
		cfg_data  <= {{(REG_WIDTH-1){1'b0}}, act};
		@(posedge clk);
		cfg_index <= REG_DEBOUNCE_TICKS;
		cfg_data  <= deb;
		@(posedge clk);
		cfg_index <= REG_LONG_TICKS;
		cfg_data  <= lng;
		@(posedge clk);
		cfg_index <= REG_EXTRA_LONG_TICKS;
		cfg_data  <= xl;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly whole press and release cycles, some glitches and noise
	task automatic random_presses(input int n_items);
		int  done_items;
		int  span;
		int  press_len;
		int  release_len;
		int  k;
		logic pin;
		done_items = 0;
		span = int'(xl_set) + int'(deb_set) + 20;
		if (int'(long_set) + int'(deb_set) + 20 > span)
			span = int'(long_set) + int'(deb_set) + 20;
		if (span > SPAN_CAP)
			span = SPAN_CAP;
		while (done_items < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				press_len = $urandom_range(1, 6);
				for (k = 0; k < press_len; k++)
					send_pin(1'($urandom_range(0, 1)));
				done_items += press_len;
			end else begin
				press_len   = $urandom_range(1, span);
				release_len = int'(deb_set) + $urandom_range(1, 8);
				if (release_len > SPAN_CAP)
					release_len = SPAN_CAP;
				for (k = 0; k < press_len + release_len; k++) begin
					pin = (k < press_len) ? act_level : ~act_level;
					if ($urandom_range(0, 49) == 0)
						pin = ~pin;
					send_pin(pin);
				end
				done_items += press_len + release_len;
			end
		end
	endtask

	// Receiver: random stalls, one long counted hold-off
	initial begin
		int held;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_off_done && sent_items >= HOLD_OFF_AT) begin
				hold_off_done = 1'b1;
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
			end else begin
				out_stall <= !quiet_now() && ($urandom_range(0, 99) < 24);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int ph;
		int k;
		logic [11:0] seq_a;
		logic [9:0]  seq_b;
		seq_a = 12'b1100_1110_0111;
		seq_b = 10'b0100_0011_11;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three ticks at the reset settings
		send_pin(1'b1);
		send_pin(1'b0);
		send_pin(1'b0);
		wait_drained();

		// zero debounce, short thresholds, high active level
		load_settings(1'b1, 16'd0, 16'd1, 16'd3);
		for (k = 11; k >= 0; k--)
			send_pin(seq_a[k]);
		wait_drained();

		// thresholds out of order, glitch dropped during debounce
		load_settings(1'b0, 16'd2, 16'd5, 16'd1);
		for (k = 9; k >= 0; k--)
			send_pin(seq_b[k]);
		wait_drained();

		// random presses over several settings
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_settings(1'b0, 16'd0, 16'd0, 16'd0);
				1: load_settings(1'b1, 16'd3, 16'd20, 16'd60);
				2: load_settings(1'($urandom_range(0, 1)), 16'd5, 16'd50, 16'd10);
				default: load_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 60)), 16'($urandom_range(0, 150)));
			endcase
			random_presses(250);
			wait_drained();
		end

		// full-range register values
		load_settings(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_presses(150);
		wait_drained();

		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
